[sv/smt_pkg.sv]
// Shared types, codes and the angle lookup for the servo move timer.
// No dependencies; every other file imports this package.
package smt_pkg;

  // Item kinds
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_MOVE = 1'b1
  } smt_kind_t;

  // Position codes; codes above POS_USER are stored but map to angle 0
  localparam logic [2:0] POS_OPEN = 3'd0;
  localparam logic [2:0] POS_GRIP = 3'd1;
  localparam logic [2:0] POS_TRIM = 3'd2;
  localparam logic [2:0] POS_CUT  = 3'd3;
  localparam logic [2:0] POS_USER = 3'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_ANGLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRIP_ANGLE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_ANGLE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CUT_ANGLE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_USER_ANGLE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BASE_MOVE_MS  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MS_PER_DEGREE = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_DETACH_MS     = 3'd7;

  // Timer and idle counter width; idle count saturates at all ones
  localparam int unsigned TimerW = 17;
  localparam logic [TimerW-1:0] IDLE_MAX = '1;

  typedef struct packed {
    logic [7:0]  open_angle;
    logic [7:0]  grip_angle;
    logic [7:0]  trim_angle;
    logic [7:0]  cut_angle;
    logic [7:0]  user_angle;
    logic [15:0] base_move_ms;
    logic [7:0]  ms_per_degree;
    logic [15:0] detach_after_ms;
  } smt_cfg_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] target_position;
  } smt_in_t;

  typedef struct packed {
    logic       busy_res;
    logic       attached;
    logic       write_strobe;
    logic       detach_strobe;
    logic [7:0] commanded_angle;
    logic [7:0] settled_angle;
    logic [2:0] current_position;
  } smt_out_t;

  // Configured angle of a position code
  function automatic logic [7:0] angle_of(input logic [2:0] pos, input smt_cfg_t cfg);
    logic [7:0] ang;
    unique case (pos)
      POS_OPEN: ang = cfg.open_angle;
      POS_GRIP: ang = cfg.grip_angle;
      POS_TRIM: ang = cfg.trim_angle;
      POS_CUT:  ang = cfg.cut_angle;
      POS_USER: ang = cfg.user_angle;
      default:  ang = 8'd0;
    endcase
    return ang;
  endfunction

endpackage

[sv/smt_cfg.sv]
// Configuration register file for the servo move timer.
// Depends on smt_pkg for register indexes and the smt_cfg_t bundle.
module smt_cfg
  import smt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output smt_cfg_t            cfg
);

  // Write one register per enabled cycle; clear all on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OPEN_ANGLE:    cfg.open_angle      <= cfg_wdata[7:0];
        CFG_GRIP_ANGLE:    cfg.grip_angle      <= cfg_wdata[7:0];
        CFG_TRIM_ANGLE:    cfg.trim_angle      <= cfg_wdata[7:0];
        CFG_CUT_ANGLE:     cfg.cut_angle       <= cfg_wdata[7:0];
        CFG_USER_ANGLE:    cfg.user_angle      <= cfg_wdata[7:0];
        CFG_BASE_MOVE_MS:  cfg.base_move_ms    <= cfg_wdata;
        CFG_MS_PER_DEGREE: cfg.ms_per_degree   <= cfg_wdata[7:0];
        CFG_DETACH_MS:     cfg.detach_after_ms <= cfg_wdata;
        default:           cfg                 <= cfg;
      endcase
    end
  end

endmodule

[sv/smt_core.sv]
// Move timer state and per-item update logic for the servo move timer.
// Depends on smt_pkg; the state advances once for each item stepped in.
module smt_core
  import smt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  smt_in_t  item,
  input  smt_cfg_t cfg,
  output smt_out_t result
);

  logic              moving,        moving_next;
  logic [TimerW-1:0] remaining_ms,  remaining_ms_next;
  logic [TimerW-1:0] idle_ms,       idle_ms_next;
  logic [2:0]        position_reg,  position_reg_next;
  logic [7:0]        settled_deg,   settled_deg_next;
  logic              attached_flag, attached_flag_next;
  logic              write_strobe,  detach_strobe;

  logic [7:0]  move_angle;
  logic [7:0]  travel;
  logic [15:0] move_product;

  // Move time: base plus per-degree cost over the distance from the settled angle
  assign move_angle   = angle_of(item.target_position, cfg);
  assign travel       = (settled_deg > move_angle) ? (settled_deg - move_angle)
                                                   : (move_angle - settled_deg);
  assign move_product = travel * cfg.ms_per_degree;

  // Next state for one item
  always_comb begin
    moving_next        = moving;
    remaining_ms_next  = remaining_ms;
    idle_ms_next       = idle_ms;
    position_reg_next  = position_reg;
    settled_deg_next   = settled_deg;
    attached_flag_next = attached_flag;
    write_strobe       = 1'b0;
    detach_strobe      = 1'b0;
    priority if (item.kind == KIND_MOVE) begin
      remaining_ms_next  = {1'b0, cfg.base_move_ms} + {1'b0, move_product};
      moving_next        = 1'b1;
      attached_flag_next = 1'b1;
      position_reg_next  = item.target_position;
      write_strobe       = 1'b1;
    end else if (moving) begin
      idle_ms_next = '0;
      if (remaining_ms == '0) begin
        moving_next      = 1'b0;
        settled_deg_next = angle_of(position_reg, cfg);
      end else begin
        remaining_ms_next = remaining_ms - 1'b1;
      end
    end else begin
      if (idle_ms != IDLE_MAX) begin
        idle_ms_next = idle_ms + 1'b1;
      end
      if (attached_flag && (position_reg == POS_OPEN) &&
          (idle_ms_next > {1'b0, cfg.detach_after_ms})) begin
        attached_flag_next = 1'b0;
        detach_strobe      = 1'b1;
      end
    end
  end

  // Result reflects the state after the update
  always_comb begin
    result.busy_res         = moving_next;
    result.attached         = attached_flag_next;
    result.write_strobe     = write_strobe;
    result.detach_strobe    = detach_strobe;
    result.commanded_angle  = angle_of(position_reg_next, cfg);
    result.settled_angle    = settled_deg_next;
    result.current_position = position_reg_next;
  end

  // Advance state on each stepped item
  always_ff @(posedge clk) begin
    if (rst) begin
      moving        <= 1'b0;
      remaining_ms  <= '0;
      idle_ms       <= '0;
      position_reg  <= POS_OPEN;
      settled_deg   <= 8'd0;
      attached_flag <= 1'b0;
    end else if (step) begin
      moving        <= moving_next;
      remaining_ms  <= remaining_ms_next;
      idle_ms       <= idle_ms_next;
      position_reg  <= position_reg_next;
      settled_deg   <= settled_deg_next;
      attached_flag <= attached_flag_next;
    end
  end

  // A moving servo is always attached
  a_moving_attached: assert property (@(posedge clk) disable iff (rst)
    moving |-> attached_flag)
    else $error("servo moving while detached");

  // A move item leaves the servo timing
  a_move_starts: assert property (@(posedge clk) disable iff (rst)
    (step && item.kind == KIND_MOVE) |=> moving)
    else $error("move item did not start the timer");

  // The tick that finds the timer at zero ends the move
  a_move_ends: assert property (@(posedge clk) disable iff (rst)
    (step && item.kind == KIND_TICK && moving && remaining_ms == '0) |=> !moving)
    else $error("expired move did not end");

  // Detach only happens on a tick while idle at the open position
  a_detach_idle: assert property (@(posedge clk) disable iff (rst)
    (step && detach_strobe) |=> (!attached_flag && !moving && position_reg == POS_OPEN))
    else $error("detach outside idle open state");

endmodule

[sv/servo_move_timer.sv]
// Servo move timer top level: input register, update logic, result register.
// Depends on smt_pkg, smt_cfg and smt_core.
// The input register takes the item at its transfer, and the result register loads
// when that item is stepped; a stalled result
// holds the input register, which then stalls the input.
// Throughput: one item per cycle unless the result stalls; the move-time multiply and
// add sit between the input register and the result register.
// Reset (synchronous rst): empties both registers, clears all config and state.
module servo_move_timer
  import smt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smt_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output smt_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  smt_cfg_t cfg;
  logic     item_vld;
  smt_in_t  item;
  logic     out_ready;
  logic     step;
  smt_out_t result;

  smt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  smt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Handshake: step the held item when the result register can take it
  assign out_ready = !out_valid || !out_stall;
  assign step      = item_vld && out_ready;
  assign in_stall  = item_vld && !out_ready;

  // Input register: load on a transfer, drop once stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (!in_stall) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

[verif/servo_move_timer_chk.sv]
// Checker for the servo move timer: predicts each result and compares transfers.
// Depends on smt_pkg; the testbench top instantiates it beside the block.
`timescale 1ns / 1ps

module servo_move_timer_chk
  import smt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  smt_in_t             in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  smt_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  compared,
  output int                  moves,
  output int                  detaches
);

  // Shadow copy of the registers and the servo state
  smt_cfg_t          regs;
  logic              moving;
  logic [TimerW-1:0] remaining;
  logic [TimerW-1:0] idle;
  logic [2:0]        position;
  logic [7:0]        settled;
  logic              attached;

  smt_out_t status_q[$];
  smt_out_t want;
  smt_out_t got;

  function automatic logic [7:0] position_angle(input logic [2:0] p);
    case (p)
      POS_OPEN: return regs.open_angle;
      POS_GRIP: return regs.grip_angle;
      POS_TRIM: return regs.trim_angle;
      POS_CUT:  return regs.cut_angle;
      POS_USER: return regs.user_angle;
      default:  return 8'd0;
    endcase
  endfunction

  // Apply one item to the shadow state and return the status it produces
  function automatic smt_out_t advance_servo(input smt_in_t it);
    smt_out_t   r;
    logic [7:0] target_deg;
    logic [7:0] span;
    r = '0;
    if (it.kind == KIND_MOVE) begin
      target_deg = position_angle(it.target_position);
      span = (settled > target_deg) ? settled - target_deg : target_deg - settled;
      remaining = TimerW'(regs.base_move_ms) + TimerW'(span) * TimerW'(regs.ms_per_degree);
      moving = 1'b1;
      attached = 1'b1;
      position = it.target_position;
      r.write_strobe = 1'b1;
    end else if (moving) begin
      // ticks during a move count down; the tick after zero settles
      idle = '0;
      if (remaining == '0) begin
        moving = 1'b0;
        settled = position_angle(position);
      end else begin
        remaining = remaining - 1'b1;
      end
    end else begin
      if (idle != IDLE_MAX) idle = idle + 1'b1;
      if (attached && position == POS_OPEN && idle > TimerW'(regs.detach_after_ms)) begin
        attached = 1'b0;
        r.detach_strobe = 1'b1;
      end
    end
    r.busy_res = moving;
    r.attached = attached;
    r.commanded_angle = position_angle(position);
    r.settled_angle = settled;
    r.current_position = position;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Sample mid-cycle: every transfer seen here completes at the next rising edge
  always @(negedge clk) begin
    if (rst) begin
      regs = '0;
      moving = 1'b0;
      remaining = '0;
      idle = '0;
      position = POS_OPEN;
      settled = 8'd0;
      attached = 1'b0;
      status_q.delete();
    end else begin
      // track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_OPEN_ANGLE:    regs.open_angle = cfg_wdata[7:0];
          CFG_GRIP_ANGLE:    regs.grip_angle = cfg_wdata[7:0];
          CFG_TRIM_ANGLE:    regs.trim_angle = cfg_wdata[7:0];
          CFG_CUT_ANGLE:     regs.cut_angle = cfg_wdata[7:0];
          CFG_USER_ANGLE:    regs.user_angle = cfg_wdata[7:0];
          CFG_BASE_MOVE_MS:  regs.base_move_ms = cfg_wdata;
          CFG_MS_PER_DEGREE: regs.ms_per_degree = cfg_wdata[7:0];
          CFG_DETACH_MS:     regs.detach_after_ms = cfg_wdata;
          default: ;
        endcase
      end

      // compare the result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        got = out_data;
        if (status_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = status_q.pop_front();
          compared++;
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("attached", want.attached, got.attached);
          check_field("write_strobe", want.write_strobe, got.write_strobe);
          check_field("detach_strobe", want.detach_strobe, got.detach_strobe);
          check_field("commanded_angle", want.commanded_angle, got.commanded_angle);
          check_field("settled_angle", want.settled_angle, got.settled_angle);
          check_field("current_position", want.current_position, got.current_position);
        end
      end

      // predict the input transfer
      if (in_valid && !in_stall) begin
        want = advance_servo(in_data);
        if (want.write_strobe) moves++;
        if (want.detach_strobe) detaches++;
        status_q.push_back(want);
      end
    end
    outstanding = status_q.size();
  end

endmodule

[verif/servo_move_timer_tb.sv]
// Testbench top for the servo move timer: clock, reset, register setup, stimulus.
// Depends on smt_pkg, servo_move_timer and servo_move_timer_chk.
`timescale 1ns / 1ps

module servo_move_timer_tb;
  import smt_pkg::*;

  localparam int HoldCycles = 120;
  localparam int IdleRun = 60;
  localparam int RandomPhases = 6;
  localparam int PhaseItems = 110;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  smt_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  smt_out_t            out_data;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int errors;
  int pending;
  int compared;
  int moves;
  int detaches;

  int items_sent;
  int settings;
  int burst_left;
  bit hold_req;

  servo_move_timer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  servo_move_timer_chk chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (errors),
    .outstanding (pending),
    .compared    (compared),
    .moves       (moves),
    .detaches    (detaches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #20_000_000;
    $display("servo_move_timer_tb failed");
    $finish;
  end

  // Receiver: random stall segments, plus a long hold-off when asked
  initial begin
    int seg;
    int mode;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        seg = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        repeat (seg) begin
          out_stall <= ($urandom_range(0, 3) < mode);
          @(posedge clk);
        end
      end
    end
  end

  function automatic smt_in_t tick_item();
    smt_in_t it;
    it.kind = KIND_TICK;
    it.target_position = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic smt_in_t move_item(input logic [2:0] pos);
    smt_in_t it;
    it.kind = KIND_MOVE;
    it.target_position = pos;
    return it;
  endfunction

  // Offer one item in bursts with random gaps; return after its transfer
  task automatic send(input smt_in_t item);
    bit taken;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has been seen
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers, one per cycle
  task automatic load_regs(input smt_cfg_t c);
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = CfgIdxW'(i);
      case (idx)
        CFG_OPEN_ANGLE:    val = {8'd0, c.open_angle};
        CFG_GRIP_ANGLE:    val = {8'd0, c.grip_angle};
        CFG_TRIM_ANGLE:    val = {8'd0, c.trim_angle};
        CFG_CUT_ANGLE:     val = {8'd0, c.cut_angle};
        CFG_USER_ANGLE:    val = {8'd0, c.user_angle};
        CFG_BASE_MOVE_MS:  val = c.base_move_ms;
        CFG_MS_PER_DEGREE: val = {8'd0, c.ms_per_degree};
        default:           val = c.detach_after_ms;
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  initial begin
    smt_cfg_t   c;
    logic [7:0] lo;
    int         r;
    logic [2:0] pos;

    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: zero-time move ends on the next tick, detach right after
    send(tick_item());
    send(move_item(POS_OPEN));
    send(tick_item());
    send(tick_item());
    wait_idle();

    // Short moves: restart while moving, undefined codes, detach at open
    c = '{open_angle: 8'd0, grip_angle: 8'd3, trim_angle: 8'd1, cut_angle: 8'd180,
          user_angle: 8'd2, base_move_ms: 16'd1, ms_per_degree: 8'd2,
          detach_after_ms: 16'd3};
    load_regs(c);
    send(move_item(POS_GRIP));
    repeat (2) send(tick_item());
    send(move_item(POS_TRIM));
    repeat (4) send(tick_item());
    send(move_item(3'd5));
    repeat (5) send(tick_item());
    send(move_item(3'd7));
    send(move_item(POS_OPEN));
    repeat (6) send(tick_item());
    wait_idle();

    // Random phases; phases may end mid-move so angles change under a move
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph % 2 == 1) begin
        lo = 8'($urandom_range(0, 168));
        c.open_angle = lo + 8'($urandom_range(0, 12));
        c.grip_angle = lo + 8'($urandom_range(0, 12));
        c.trim_angle = lo + 8'($urandom_range(0, 12));
        c.cut_angle = lo + 8'($urandom_range(0, 12));
        c.user_angle = lo + 8'($urandom_range(0, 12));
        c.ms_per_degree = 8'($urandom_range(0, 2));
      end else begin
        c.open_angle = 8'($urandom_range(0, 180));
        c.grip_angle = 8'($urandom_range(0, 180));
        c.trim_angle = 8'($urandom_range(0, 180));
        c.cut_angle = 8'($urandom_range(0, 180));
        c.user_angle = 8'($urandom_range(0, 180));
        c.ms_per_degree = 8'd0;
      end
      c.base_move_ms = 16'($urandom_range(0, 6));
      c.detach_after_ms = (ph == 0) ? 16'd0 : 16'($urandom_range(0, 12));
      load_regs(c);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(0, 99);
        if (r < 7) begin
          r = $urandom_range(0, 15);
          if (r < 6) pos = POS_OPEN;
          else if (r < 14) pos = 3'($urandom_range(1, 4));
          else pos = 3'($urandom_range(5, 7));
          send(move_item(pos));
        end else begin
          send(tick_item());
        end
      end
      wait_idle();
    end

    // Largest move times
    c = '{open_angle: 8'd180, grip_angle: 8'd0, trim_angle: 8'd0, cut_angle: 8'd180,
          user_angle: 8'd180, base_move_ms: 16'hFFFF, ms_per_degree: 8'hFF,
          detach_after_ms: 16'hFFFF};
    load_regs(c);
    send(move_item(POS_CUT));
    repeat (3) send(tick_item());
    send(move_item(POS_GRIP));
    repeat (3) send(tick_item());
    wait_idle();

    // Long idle at open: detach after a longer delay, then keep ticking idle
    c = '{open_angle: 8'd90, grip_angle: 8'd45, trim_angle: 8'd135, cut_angle: 8'd10,
          user_angle: 8'd170, base_move_ms: 16'd0, ms_per_degree: 8'd0,
          detach_after_ms: 16'd40};
    load_regs(c);
    send(move_item(POS_OPEN));
    repeat (IdleRun) send(tick_item());
    wait_idle();

    $display("covered %0d items under %0d register settings, with moves, restarts and idling",
             items_sent, settings);
    $display("%0d moves, %0d detaches, %0d results compared", moves, detaches, compared);
    if (errors == 0) begin
      $display("servo_move_timer_tb passed");
    end else begin
      $display("servo_move_timer_tb failed");
    end
    $finish;
  end

endmodule

[servo_move_timer.f]
sv/smt_pkg.sv
sv/smt_cfg.sv
sv/smt_core.sv
sv/servo_move_timer.sv
verif/servo_move_timer_chk.sv
verif/servo_move_timer_tb.sv
